>>> hw/rtl/pru_pkg.sv
// page replacement unit package: sizes, policy codes, controller/datapath structs
// no dependencies
`timescale 1ns / 1ps
package pru_pkg;
	localparam int unsigned FRAME_SLOTS_DEF = 16;
	localparam int unsigned PAGE_BITS_DEF   = 16;
	localparam int unsigned STAMP_BITS_DEF  = 32;
	localparam int unsigned PAGE_W  = 16;
	localparam int unsigned SLOT_W  = 4;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned FRAMES_W = 5;
	localparam int unsigned POLICY_W = 2;

	localparam logic [FRAMES_W-1:0] FRAMES_RESET = 5'd16;

	localparam logic [POLICY_W-1:0] POL_FIFO  = 2'd0;
	localparam logic [POLICY_W-1:0] POL_LRU   = 2'd1;
	localparam logic [POLICY_W-1:0] POL_CLOCK = 2'd2;
	localparam logic [POLICY_W-1:0] POL_ESC   = 2'd3;

	localparam logic [0:0] REG_FRAMES = 1'b0;
	localparam logic [0:0] REG_POLICY = 1'b1;

	typedef struct packed {
		logic load;
		logic lookup;
		logic scan_init;
		logic scan_step;
		logic commit;
	} pru_cmd_t;

	typedef struct packed {
		logic hit;
		logic quick;
		logic scan_done;
	} pru_sts_t;
endpackage

>>> hw/rtl/page_replacement_unit.sv
// page replacement unit top level: config registers, controller and datapath
// depends on pru_pkg, pru_ctrl, pru_datapath
//
// a request is taken when start is high and busy is low; busy stays high
// until the result has been shown. the result (hit, frame_slot, fault_total)
// is valid for one cycle while done is high and cannot be held off.
// a hit or a free/FIFO fill skips the victim search and goes to commit.
// LRU faults walk the stamps one frame a cycle; clock and enhanced clock
// faults step the hand one frame a cycle.
// configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high. the user must make writes only while idle; the block itself
// does not enforce it. index 0 frames_in_use, 1 policy.
// reset clears the frame table marks, hand and counters; frames_in_use
// comes up as 16 and policy as FIFO.
`timescale 1ns / 1ps
module page_replacement_unit #(
	parameter int unsigned FRAME_SLOTS = pru_pkg::FRAME_SLOTS_DEF,
	parameter int unsigned PAGE_BITS   = pru_pkg::PAGE_BITS_DEF,
	parameter int unsigned STAMP_BITS  = pru_pkg::STAMP_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	output logic                          done,
	input  logic [pru_pkg::PAGE_W-1:0]    page,
	input  logic                          is_write,
	output logic                          hit,
	output logic [pru_pkg::SLOT_W-1:0]    frame_slot,
	output logic [pru_pkg::COUNT_W-1:0]   fault_total,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [0:0]                    cfg_index,
	input  logic [31:0]                   cfg_data
);
	import pru_pkg::*;
	logic [FRAMES_W-1:0] frames_q;
	logic [POLICY_W-1:0] policy_q;
	pru_cmd_t cmd;
	pru_sts_t sts;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
			policy_q <= POL_FIFO;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAMES: frames_q <= cfg_data[FRAMES_W-1:0];
				REG_POLICY: policy_q <= cfg_data[POLICY_W-1:0];
				default: ;
			endcase
		end
	end

	pru_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.sts(sts), .cmd(cmd)
	);

	pru_datapath #(
		.FRAME_SLOTS(FRAME_SLOTS), .PAGE_BITS(PAGE_BITS), .STAMP_BITS(STAMP_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .page(page),
		.is_write(is_write), .frames_in_use(frames_q), .policy(policy_q),
		.hit(hit), .frame_slot(frame_slot), .fault_total(fault_total)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("done without busy");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(cmd))
		else $error("more than one command");
	a_fault_mono: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> $stable(fault_total) || $past(fault_total) == fault_total)
		else $error("fault count moved on a hit");
endmodule

>>> hw/rtl/pru_datapath.sv
// page replacement unit datapath: frame table, lookup, victim search, counters
// depends on pru_pkg
`timescale 1ns / 1ps
module pru_datapath #(
	parameter int unsigned FRAME_SLOTS = pru_pkg::FRAME_SLOTS_DEF,
	parameter int unsigned PAGE_BITS   = pru_pkg::PAGE_BITS_DEF,
	parameter int unsigned STAMP_BITS  = pru_pkg::STAMP_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pru_pkg::pru_cmd_t             cmd,
	output pru_pkg::pru_sts_t             sts,
	input  logic [pru_pkg::PAGE_W-1:0]    page,
	input  logic                          is_write,
	input  logic [pru_pkg::FRAMES_W-1:0]  frames_in_use,
	input  logic [pru_pkg::POLICY_W-1:0]  policy,
	output logic                          hit,
	output logic [pru_pkg::SLOT_W-1:0]    frame_slot,
	output logic [pru_pkg::COUNT_W-1:0]   fault_total
);
	import pru_pkg::*;
	localparam int unsigned IW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
	localparam int unsigned NW = $clog2(FRAME_SLOTS + 1);
	localparam int unsigned SW = $clog2(4 * FRAME_SLOTS + 2);

	logic [PAGE_BITS-1:0]  page_q [FRAME_SLOTS];
	logic [STAMP_BITS-1:0] stamp_q [FRAME_SLOTS];
	logic [FRAME_SLOTS-1:0] valid_q, ref_q, dirty_q;
	logic [IW-1:0] hand_q, h_q, cur_q, idx_q;
	logic [NW-1:0] n_q;
	logic [PAGE_BITS-1:0] req_page_q;
	logic wr_q, hit_q;
	logic [1:0] pass_q;
	logic [SW-1:0] steps_q;
	logic [COUNT_W-1:0] refnum_q, fault_q;
	logic [POLICY_W-1:0] pol_q;

	logic [NW-1:0] n_c;
	logic [IW-1:0] h_c, nxt_c, hit_idx_c, free_idx_c, hand_nxt_c;
	logic hit_c, free_c;
	logic [FRAME_SLOTS-1:0] inwin_c;
	logic d_c, r_c, found_c;

	always_comb begin
		if (frames_in_use == '0) n_c = NW'(1);
		else if (32'(frames_in_use) > FRAME_SLOTS) n_c = NW'(FRAME_SLOTS);
		else n_c = NW'(frames_in_use);
		h_c = (32'(hand_q) < 32'(n_c)) ? hand_q : '0;
	end

	always_comb begin
		hit_c = 1'b0;
		hit_idx_c = '0;
		for (int i = FRAME_SLOTS - 1; i >= 0; i--) begin
			inwin_c[i] = (i < 32'(n_q));
			if (inwin_c[i] && valid_q[i] && page_q[i] == req_page_q) begin
				hit_c = 1'b1;
				hit_idx_c = IW'(i);
			end
		end
	end

	// lru: sequential walk with running minimum
	logic [STAMP_BITS-1:0] best_stamp_q;
	always_comb begin
		free_c = 1'b0;
		free_idx_c = '0;
		for (int i = FRAME_SLOTS - 1; i >= 0; i--)
			if (i < 32'(n_q) && !valid_q[i]) begin
				free_c = 1'b1;
				free_idx_c = IW'(i);
			end
	end

	always_comb begin
		nxt_c = (32'(cur_q) + 1 >= 32'(n_q)) ? '0 : cur_q + IW'(1);
		d_c = valid_q[cur_q] ? dirty_q[cur_q] : 1'b0;
		r_c = valid_q[cur_q] ? ref_q[cur_q] : 1'b0;
		if (pol_q == POL_CLOCK) found_c = !valid_q[cur_q] || !ref_q[cur_q];
		else if (pol_q == POL_ESC) found_c = !r_c && (d_c == pass_q[0]);
		else found_c = 1'b0;
	end

	assign hand_nxt_c = (pol_q == POL_FIFO || pol_q == POL_LRU)
		? ((32'(h_q) + 1 >= 32'(n_q)) ? '0 : h_q + IW'(1))
		: ((32'(idx_q) + 1 >= 32'(n_q)) ? '0 : idx_q + IW'(1));

	logic done_q;
	assign sts.hit = hit_c;
	assign sts.quick = !valid_q[h_q] || pol_q == POL_FIFO;
	assign sts.scan_done = done_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_page_q <= PAGE_BITS'(page);
			wr_q <= is_write;
		end
		if (cmd.commit && !hit_q) page_q[idx_q] <= req_page_q;
		if (cmd.commit) stamp_q[idx_q] <= STAMP_BITS'(refnum_q);
		if (cmd.scan_step && pol_q == POL_LRU && !done_q && 32'(cur_q) < 32'(n_q)
			&& stamp_q[cur_q] < best_stamp_q)
			best_stamp_q <= stamp_q[cur_q];
		if (cmd.scan_init) best_stamp_q <= stamp_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0; ref_q <= '0; dirty_q <= '0;
			hand_q <= '0; h_q <= '0; cur_q <= '0; idx_q <= '0; n_q <= '0;
			hit_q <= 1'b0; pass_q <= '0; steps_q <= '0; refnum_q <= '0;
			fault_q <= '0; pol_q <= '0; done_q <= 1'b0;
			hit <= 1'b0; frame_slot <= '0; fault_total <= '0;
		end else begin
			if (cmd.load) begin
				n_q <= n_c;
				h_q <= h_c;
				pol_q <= policy;
			end
			if (cmd.lookup) begin
				hit_q <= hit_c;
				idx_q <= hit_c ? hit_idx_c : h_q;
			end
			if (cmd.scan_init) begin
				done_q <= 1'b0;
				pass_q <= '0;
				steps_q <= '0;
				if (pol_q == POL_LRU) begin
					if (free_c) begin
						idx_q <= free_idx_c;
						done_q <= 1'b1;
					end else begin
						idx_q <= '0;
						cur_q <= IW'(1);
					end
				end else cur_q <= h_q;
			end
			if (cmd.scan_step && !done_q) begin
				if (pol_q == POL_LRU) begin
					if (32'(cur_q) >= 32'(n_q) || cur_q == '0) done_q <= 1'b1;
					else begin
						if (stamp_q[cur_q] < best_stamp_q) idx_q <= cur_q;
						if (32'(cur_q) + 1 >= 32'(n_q)) done_q <= 1'b1;
						else cur_q <= cur_q + IW'(1);
					end
				end else if (pol_q == POL_CLOCK) begin
					if (found_c) begin
						idx_q <= cur_q; done_q <= 1'b1;
					end else if (32'(steps_q) >= 2 * 32'(n_q)) begin
						ref_q[cur_q] <= 1'b0; idx_q <= h_q; done_q <= 1'b1;
					end else begin
						ref_q[cur_q] <= 1'b0;
						cur_q <= nxt_c;
						steps_q <= steps_q + SW'(1);
					end
				end else begin
					if (found_c) begin
						idx_q <= cur_q; done_q <= 1'b1;
					end else begin
						if (pass_q == 2'd1) ref_q[cur_q] <= 1'b0;
						cur_q <= nxt_c;
						if (32'(steps_q) + 1 >= 32'(n_q)) begin
							steps_q <= '0;
							if (pass_q == 2'd3) begin
								idx_q <= h_q; done_q <= 1'b1;
							end else pass_q <= pass_q + 2'd1;
						end else steps_q <= steps_q + SW'(1);
					end
				end
			end
			if (cmd.commit) begin
				refnum_q <= refnum_q + COUNT_W'(1);
				ref_q[idx_q] <= 1'b1;
				if (hit_q) begin
					if (wr_q) dirty_q[idx_q] <= 1'b1;
					hand_q <= h_q;
				end else begin
					valid_q[idx_q] <= 1'b1;
					dirty_q[idx_q] <= wr_q;
					hand_q <= hand_nxt_c;
					if (fault_q != '1) fault_q <= fault_q + COUNT_W'(1);
				end
				hit <= hit_q;
				frame_slot <= SLOT_W'(idx_q);
				fault_total <= (!hit_q && fault_q != '1) ? fault_q + COUNT_W'(1) : fault_q;
			end
		end
	end
endmodule

>>> hw/rtl/pru_ctrl.sv
// page replacement unit controller: sequences lookup, victim search and commit
// depends on pru_pkg
`timescale 1ns / 1ps
module pru_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  pru_pkg::pru_sts_t  sts,
	output pru_pkg::pru_cmd_t  cmd
);
	import pru_pkg::*;
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_LOOKUP = 6'b000010,
		ST_INIT   = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_COMMIT = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;
	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = start;
				if (start) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d = (sts.hit || sts.quick) ? ST_COMMIT : ST_INIT;
			end
			ST_INIT: begin
				cmd.scan_init = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end
	assign busy = state_q != ST_IDLE;
	assign done = state_q == ST_OUT;
endmodule

>>> tb/testbench.sv
// testbench for page_replacement_unit: directed table then random page references
// under all four policies and a set of frame counts, checked against a frame-table predictor
// depends on pru_pkg and page_replacement_unit
`timescale 1ns / 1ps
module testbench;
	import pru_pkg::*;

	typedef struct {
		bit              hit;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] total;
		bit              typed;
		bit              t_hit;
		logic [SLOT_W-1:0]  t_slot;
		logic [COUNT_W-1:0] t_total;
	} ref_result_t;

	typedef struct {
		bit              is_cfg;
		logic [0:0]      idx;
		logic [31:0]     data;
		logic [PAGE_W-1:0] pg;
		bit              wr;
		bit              typed;
		bit              t_hit;
		logic [SLOT_W-1:0]  t_slot;
		logic [COUNT_W-1:0] t_total;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [PAGE_W-1:0] page = '0;
	logic is_write = 0;
	logic cfg_valid = 0;
	logic [0:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic busy, done, hit, cfg_ready;
	logic [SLOT_W-1:0] frame_slot;
	logic [COUNT_W-1:0] fault_total;

	page_replacement_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.page(page), .is_write(is_write), .hit(hit), .frame_slot(frame_slot),
		.fault_total(fault_total), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predicted frame table
	logic [PAGE_W-1:0] fr_page [16];
	logic [31:0] fr_stamp [16];
	bit fr_valid [16];
	bit fr_ref [16];
	bit fr_dirty [16];
	int unsigned hand_pos = 0;
	logic [31:0] ref_num = 0;
	logic [31:0] faults = 0;
	logic [FRAMES_W-1:0] frames_cfg = FRAMES_RESET;
	logic [POLICY_W-1:0] policy_cfg = POL_FIFO;

	ref_result_t pending_refs [$];
	int errors = 0;
	int refs_done = 0;
	int hits_seen = 0;
	int settings_seen = 0;
	int idle_cycles = 0;
	int gap_pct = 0;
	bit cur_typed = 0, cur_t_hit = 0;
	logic [SLOT_W-1:0] cur_t_slot = 0;
	logic [COUNT_W-1:0] cur_t_total = 0;

	function automatic int esc_scan(int st, int n, bit want_dirty, bit clr);
		int i;
		bit d, r;
		i = st;
		for (int s = 0; s < n; s++) begin
			d = fr_valid[i] ? fr_dirty[i] : 0;
			r = fr_valid[i] ? fr_ref[i] : 0;
			if (!r && d == want_dirty)
				return i;
			if (clr)
				fr_ref[i] = 0;
			i = (i + 1) % n;
		end
		return -1;
	endfunction

	function automatic ref_result_t replace_lookup(logic [PAGE_W-1:0] pg, bit wr);
		ref_result_t res;
		int n, h, idx, v;
		bit found;
		n = (frames_cfg == 0) ? 1 : (frames_cfg > 16) ? 16 : int'(frames_cfg);
		h = (hand_pos < n) ? hand_pos : 0;
		idx = 0;
		found = 0;
		for (int i = 0; i < n; i++)
			if (!found && fr_valid[i] && fr_page[i] == pg) begin
				idx = i;
				found = 1;
			end
		if (found) begin
			fr_ref[idx] = 1;
			if (wr)
				fr_dirty[idx] = 1;
			hand_pos = h;
		end else begin
			if (!fr_valid[h] || policy_cfg == POL_FIFO) begin
				idx = h;
			end else if (policy_cfg == POL_LRU) begin
				idx = -1;
				for (int i = 0; i < n; i++)
					if (idx < 0 && !fr_valid[i])
						idx = i;
				if (idx < 0) begin
					idx = 0;
					for (int i = 1; i < n; i++)
						if (fr_stamp[i] < fr_stamp[idx])
							idx = i;
				end
			end else if (policy_cfg == POL_CLOCK) begin
				v = h;
				idx = -1;
				for (int s = 0; s <= 2 * n && idx < 0; s++) begin
					if (!fr_valid[v] || !fr_ref[v]) begin
						idx = v;
					end else begin
						fr_ref[v] = 0;
						v = (v + 1) % n;
					end
				end
				if (idx < 0)
					idx = h;
			end else begin
				v = esc_scan(h, n, 0, 0);
				if (v < 0) v = esc_scan(h, n, 1, 1);
				if (v < 0) v = esc_scan(h, n, 0, 0);
				if (v < 0) v = esc_scan(h, n, 1, 0);
				idx = (v < 0) ? h : v;
			end
			fr_page[idx] = pg;
			fr_valid[idx] = 1;
			fr_ref[idx] = 1;
			fr_dirty[idx] = wr;
			hand_pos = (policy_cfg <= POL_LRU) ? (h + 1) % n : (idx + 1) % n;
			if (faults != 32'hFFFF_FFFF)
				faults = faults + 1;
		end
		fr_stamp[idx] = ref_num;
		ref_num = ref_num + 1;
		res.hit = found;
		res.slot = idx[SLOT_W-1:0];
		res.total = faults;
		return res;
	endfunction

	always @(posedge clk) begin
		ref_result_t e;
		if (arst_n) begin
			if (done) begin
				if (pending_refs.size() == 0) begin
					$display("%0t: result with none expected: hit %0b slot %0d total %0d",
						$time, hit, frame_slot, fault_total);
					errors++;
				end else begin
					e = pending_refs.pop_front();
					refs_done++;
					if (hit) hits_seen++;
					if (hit !== e.hit || frame_slot !== e.slot || fault_total !== e.total) begin
						$display("%0t: mismatch expected hit %0b slot %0d total %0d, got %0b %0d %0d",
							$time, e.hit, e.slot, e.total, hit, frame_slot, fault_total);
						errors++;
					end
					if (e.typed && (hit !== e.t_hit || frame_slot !== e.t_slot ||
							fault_total !== e.t_total)) begin
						$display("%0t: table expected hit %0b slot %0d total %0d, got %0b %0d %0d",
							$time, e.t_hit, e.t_slot, e.t_total, hit, frame_slot, fault_total);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				e = replace_lookup(page, is_write);
				e.typed = cur_typed;
				e.t_hit = cur_t_hit;
				e.t_slot = cur_t_slot;
				e.t_total = cur_t_total;
				pending_refs.push_back(e);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_FRAMES)
					frames_cfg = cfg_data[FRAMES_W-1:0];
				else
					policy_cfg = cfg_data[POLICY_W-1:0];
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 3000) begin
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic send_ref(logic [PAGE_W-1:0] pg, bit wr);
		while ($urandom_range(99) < gap_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		page <= pg;
		is_write <= wr;
		do @(posedge clk); while (!(start && !busy));
	endtask

	task automatic drain_refs();
		start <= 0;
		@(posedge clk);
		while (pending_refs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 0;
	endtask

	row_t dir_rows [] = '{
		'{0, REG_FRAMES, 0, 16'h0000, 0, 1, 0, 0, 1},
		'{0, REG_FRAMES, 0, 16'hFFFF, 1, 1, 0, 1, 2},
		'{0, REG_FRAMES, 0, 16'h0000, 1, 1, 1, 0, 2},
		'{0, REG_FRAMES, 0, 16'hFFFF, 0, 1, 1, 1, 2},
		'{1, REG_FRAMES, 32'd2, 0, 0, 0, 0, 0, 0},
		'{0, REG_FRAMES, 0, 16'h5555, 0, 0, 0, 0, 0},
		'{0, REG_FRAMES, 0, 16'hAAAA, 1, 0, 0, 0, 0},
		'{1, REG_FRAMES, 32'd16, 0, 0, 0, 0, 0, 0},
		'{0, REG_FRAMES, 0, 16'h5555, 0, 0, 0, 0, 0},
		'{1, REG_POLICY, 32'hFFFF_FFFD, 0, 0, 0, 0, 0, 0},
		'{1, REG_FRAMES, 32'd3, 0, 0, 0, 0, 0, 0},
		'{0, REG_FRAMES, 0, 16'h0001, 0, 0, 0, 0, 0},
		'{0, REG_FRAMES, 0, 16'h0002, 1, 0, 0, 0, 0},
		'{0, REG_FRAMES, 0, 16'h0003, 0, 0, 0, 0, 0},
		'{1, REG_POLICY, {30'd0, POL_CLOCK}, 0, 0, 0, 0, 0, 0},
		'{0, REG_FRAMES, 0, 16'h0004, 0, 0, 0, 0, 0},
		'{1, REG_POLICY, {30'd0, POL_ESC}, 0, 0, 0, 0, 0, 0},
		'{0, REG_FRAMES, 0, 16'h0002, 1, 0, 0, 0, 0},
		'{0, REG_FRAMES, 0, 16'h0005, 1, 0, 0, 0, 0},
		'{1, REG_FRAMES, 32'd0, 0, 0, 0, 0, 0, 0},
		'{0, REG_FRAMES, 0, 16'h0007, 0, 0, 0, 0, 0},
		'{1, REG_FRAMES, 32'd31, 0, 0, 0, 0, 0, 0},
		'{0, REG_FRAMES, 0, 16'h0007, 0, 0, 0, 0, 0},
		'{0, REG_FRAMES, 0, 16'h8000, 1, 0, 0, 0, 0}
	};

	initial begin
		int unsigned frames_choice [] = '{1, 16, 0, 31, 2, 3, 5, 8, 12, 15, 17};
		logic [PAGE_W-1:0] base;
		int n, span;
		for (int i = 0; i < 16; i++) begin
			fr_valid[i] = 0;
			fr_ref[i] = 0;
			fr_dirty[i] = 0;
			fr_page[i] = '0;
			fr_stamp[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].is_cfg) begin
				drain_refs();
				settings_seen++;
				write_reg(dir_rows[r].idx, dir_rows[r].data);
			end else begin
				cur_typed <= dir_rows[r].typed;
				cur_t_hit <= dir_rows[r].t_hit;
				cur_t_slot <= dir_rows[r].t_slot;
				cur_t_total <= dir_rows[r].t_total;
				send_ref(dir_rows[r].pg, dir_rows[r].wr);
			end
		end
		cur_typed <= 0;

		for (int ph = 0; ph < 22; ph++) begin
			gap_pct = (ph < 7) ? 12 : (ph < 14) ? 80 : 0;
			drain_refs();
			n = frames_choice[$urandom_range(frames_choice.size() - 1)];
			write_reg(REG_FRAMES, {$urandom} & ~32'h1F | n);
			write_reg(REG_POLICY, {$urandom} & ~32'h3 | (ph % 4));
			settings_seen++;
			base = PAGE_W'($urandom);
			span = ((n == 0) ? 1 : (n > 16) ? 16 : n) + $urandom_range(1, 5);
			for (int k = 0; k < 75; k++) begin
				if ($urandom_range(9) == 0)
					send_ref(PAGE_W'($urandom), 1'($urandom_range(1)));
				else
					send_ref(base ^ PAGE_W'($urandom_range(span)), 1'($urandom_range(1)));
			end
		end

		drain_refs();
		repeat (80) @(posedge clk);
		$display("covered %0d references, %0d hits, over %0d policy/frame settings",
			refs_done, hits_seen, settings_seen);
		$display("all four policies, frame counts 0 to 31, idle gaps of 0, 12 and 80 percent");
		if (errors == 0 && pending_refs.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule

>>> filelist.f
hw/rtl/pru_pkg.sv
hw/rtl/pru_datapath.sv
hw/rtl/pru_ctrl.sv
hw/rtl/page_replacement_unit.sv
tb/testbench.sv
